/* rtl/pol_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pol_pkg: shared types and codes of the positional ordered list
// Holds the item payload structs, operation and status codes, the sequencer
// state type and the control structs passed between the sequencer and the
// top level.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int unsigned CW = 7;   // width of position and count
  localparam int unsigned VW = 32;  // width of a stored value

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_RANGE  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CW-1:0]        position;
    logic signed [VW-1:0] value;
  } pol_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [VW-1:0] read_value;
    logic [CW-1:0]        count;
    logic                 empty_res;
  } pol_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHIFT,
    ST_DRAIN,
    ST_INSWR,
    ST_RDWAIT,
    ST_FINISH
  } pol_state_t;

  // What the accepted item asks of the sequencer.
  typedef struct packed {
    logic do_move;  // entries have to be moved one place
    logic down;     // moves run toward the tail (insert)
    logic do_ins;   // the new value is written at the position
    logic do_read;  // the entry at the position is read out
  } pol_plan_t;

  // Memory port controls from the sequencer.
  typedef struct packed {
    logic we;
    logic wsel_val;  // write the item value rather than the moved entry
    logic re;
  } pol_mcmd_t;

  // Sequencer status toward the top level.
  typedef struct packed {
    logic idle;
    logic cap;  // read data is valid at the memory output
    logic fin;  // result is ready to be registered
  } pol_stat_t;

endpackage
`default_nettype wire

/* rtl/pol_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pol_ram: generic simple dual-port RAM
// One write port and one read port, registered read data, no reset of the
// contents.
// ----------------------------------------------------------------------------
module pol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/pol_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pol_seq: move sequencer of the positional ordered list
// Steps one source pointer across the entries that have to move, issuing one
// memory read per cycle and writing the previous read back one place over.
// ----------------------------------------------------------------------------
module pol_seq #(
  parameter int unsigned AW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire pol_pkg::pol_plan_t plan,
  input  wire logic [AW-1:0]     first_src,
  input  wire logic [AW-1:0]     last_src,
  input  wire logic [AW-1:0]     ins_addr,
  input  wire logic              res_free,
  output pol_pkg::pol_mcmd_t     cmd,
  output logic      [AW-1:0]     raddr,
  output logic      [AW-1:0]     waddr,
  output pol_pkg::pol_stat_t     stat
);

  import pol_pkg::*;

  pol_state_t    state_r, state_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic          wpend_r, wpend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wpend_r <= wpend_nxt;
    end
    src_r   <= src_nxt;
    waddr_r <= waddr_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    src_nxt      = src_r;
    waddr_nxt    = waddr_r;
    wpend_nxt    = 1'b0;
    cmd          = '0;
    cmd.we       = wpend_r;
    raddr        = src_r;
    waddr        = waddr_r;
    stat         = '0;
    unique case (state_r)
      ST_IDLE: begin
        stat.idle = 1'b1;
        if (start) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (plan.do_read) begin
          cmd.re    = 1'b1;
          raddr     = ins_addr;
          state_nxt = ST_RDWAIT;
        end else if (plan.do_move) begin
          src_nxt   = first_src;
          state_nxt = ST_SHIFT;
        end else if (plan.do_ins) begin
          state_nxt = ST_INSWR;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        cmd.re    = 1'b1;
        wpend_nxt = 1'b1;
        waddr_nxt = plan.down ? src_r + AW'(1) : src_r - AW'(1);
        if (src_r == last_src) begin
          state_nxt = ST_DRAIN;
        end else begin
          src_nxt = plan.down ? src_r - AW'(1) : src_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = plan.do_ins ? ST_INSWR : ST_FINISH;
      end
      ST_INSWR: begin
        cmd.we       = 1'b1;
        cmd.wsel_val = 1'b1;
        waddr        = ins_addr;
        state_nxt    = ST_FINISH;
      end
      ST_RDWAIT: begin
        stat.cap  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        stat.fin = 1'b1;
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_wpend_in_move: assert property (@(posedge clk) disable iff (!rst_n)
    wpend_r |-> (state_r == ST_SHIFT || state_r == ST_DRAIN))
    else $error("pending move write outside of a move");

  a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> ($past(state_r) == ST_IDLE))
    else $error("decide step not entered from idle");

endmodule
`default_nettype wire

/* rtl/positional_ordered_list_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_ordered_list_core: ordered list with insert and remove by index
// Keeps up to CAPACITY (at most 127) signed 32-bit entries in a memory and
// answers every insert, remove or read item with one result item.
// ----------------------------------------------------------------------------
// The list lives in a single simple dual-port RAM with a registered read, and
// an insert or remove moves the later entries one place with a small
// sequencer that reads one entry and writes the previously read entry back
// every cycle. One item is worked on at a time and in_ready is high only
// while the sequencer is idle, so the rate is set by the one-entry-per-cycle
// move loop through the RAM port pair. A finished result sits in an output
// register, so a new item is taken while the previous result still waits
// for out_ready. The usable capacity is the smaller of CAPACITY and 127,
// the largest count that the 7-bit count field can report. Status 1 reports
// a position out of range (or an unused kind), status 2 an insert into a
// full list; read_value is zero except for a successful read.
// ----------------------------------------------------------------------------
module positional_ordered_list_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pol_pkg::pol_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pol_pkg::pol_out_t     out_data
);

  import pol_pkg::*;

  // The count field caps the list length at 127 entries.
  localparam int unsigned CMAX  = (1 << CW) - 1;
  localparam int unsigned DEPTH = (CAPACITY < CMAX) ? CAPACITY : CMAX;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Latched item and list state.
  logic [1:0]           kind_r;
  logic [CW-1:0]        pos_r;
  logic signed [VW-1:0] val_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [VW-1:0]        rdv_r;
  pol_out_t             out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Decision for the latched item.
  pol_plan_t     plan;
  logic [1:0]    status;
  logic [AW-1:0] first_src, last_src, ins_addr;

  // Sequencer and memory connections.
  pol_mcmd_t     cmd;
  pol_stat_t     stat;
  logic [AW-1:0] raddr, waddr;
  logic [VW-1:0] rdata, wdata;
  logic          accept, res_free;

  assign in_ready = stat.idle;
  assign accept   = in_valid && in_ready;
  assign res_free = !out_valid_r || out_ready;

  // The item and the count do not change while the sequencer works, so the
  // plan below stays steady from the decide step to the finish step.
  always_comb begin
    plan      = '0;
    status    = STAT_RANGE;
    count_nxt = count_r;
    first_src = '0;
    last_src  = '0;
    ins_addr  = AW'(pos_r);
    unique case (kind_r)
      KIND_INSERT: begin
        priority if (pos_r > count_r) begin
          status = STAT_RANGE;
        end else if (count_r >= CW'(DEPTH)) begin
          status = STAT_FULL;
        end else begin
          status       = STAT_DONE;
          plan.do_ins  = 1'b1;
          plan.down    = 1'b1;
          plan.do_move = (pos_r != count_r);
          first_src    = AW'(count_r - CW'(1));
          last_src     = AW'(pos_r);
          count_nxt    = count_r + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (pos_r < count_r) begin
          status       = STAT_DONE;
          plan.do_move = ((pos_r + CW'(1)) != count_r);
          first_src    = AW'(pos_r + CW'(1));
          last_src     = AW'(count_r - CW'(1));
          count_nxt    = count_r - CW'(1);
        end
      end
      KIND_READ: begin
        if (pos_r < count_r) begin
          status       = STAT_DONE;
          plan.do_read = 1'b1;
        end
      end
      default: begin
        status = STAT_RANGE;
      end
    endcase
  end

  pol_seq #(
    .AW (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .plan      (plan),
    .first_src (first_src),
    .last_src  (last_src),
    .ins_addr  (ins_addr),
    .res_free  (res_free),
    .cmd       (cmd),
    .raddr     (raddr),
    .waddr     (waddr),
    .stat      (stat)
  );

  // A moved entry is written straight from the RAM output register.
  assign wdata = cmd.wsel_val ? VW'(val_r) : rdata;

  pol_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The result register is loaded at the finish step once it is free.
  always_comb begin
    out_nxt            = out_r;
    out_valid_nxt      = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.fin && res_free) begin
      out_valid_nxt      = 1'b1;
      out_nxt.status     = status;
      out_nxt.read_value = plan.do_read ? $signed(rdv_r) : '0;
      out_nxt.count      = count_nxt;
      out_nxt.empty_res  = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (stat.fin && res_free) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      kind_r <= in_data.kind;
      pos_r  <= in_data.position;
      val_r  <= in_data.value;
    end
    if (stat.cap) begin
      rdv_r <= rdata;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond list capacity");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.count == count_r))
    else $error("waiting result disagrees with the list count");

  a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.empty_res == (out_r.count == '0)))
    else $error("empty flag disagrees with the result count");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != STAT_DONE) |-> (out_r.read_value == '0))
    else $error("refused item carries a read value");

endmodule
`default_nettype wire
